### src/two_class_alternating_grant_defines.svh
// ----------------------------------------------------------------------------
// two_class_alternating_grant_defines
// Assertion macros for the two-class alternating grant arbiter.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_ALTERNATING_GRANT_DEFINES_SVH
`define TWO_CLASS_ALTERNATING_GRANT_DEFINES_SVH

`ifndef SYNTH
// checked out of reset only
`define TCAG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("two_class_alternating_grant: check failed");
// checked at every edge, reset included
`define TCAG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("two_class_alternating_grant: check failed");
`else
`define TCAG_ASSERT(lbl, prop)
`define TCAG_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### src/tcag_pkg.sv
// ----------------------------------------------------------------------------
// tcag_pkg
// Shared types and constants of the two-class alternating grant arbiter.
// ----------------------------------------------------------------------------
package tcag_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int FIELD_ID_W      = 8;

  typedef enum logic [1:0] {
    FN_REQUEST = 2'd0,
    FN_RELEASE = 2'd1,
    FN_TIMEOUT = 2'd2,
    FN_UNUSED  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    OC_QUEUED  = 3'd0,
    OC_GRANTED = 3'd1,
    OC_REMOVED = 3'd2,
    OC_NONE    = 3'd3,
    OC_FULL    = 3'd4
  } outcome_t;

  // queue operation strobes, at most one of push/pop/remove at a time
  typedef struct packed {
    logic push;
    logic pop;
    logic remove;
    logic capture;
  } q_ctl_t;

endpackage

### src/tcag_cell.sv
// ----------------------------------------------------------------------------
// tcag_cell
// One queue slot: id and timeout flag, takes its upper neighbor on a shift,
// flags a timeout match and passes the match chain upward, toward the tail.
// ----------------------------------------------------------------------------
module tcag_cell #(
  parameter int ID_W = tcag_pkg::ID_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  tcag_pkg::q_ctl_t ctl,
  input  logic            occ,
  input  logic            is_tail,
  input  logic [ID_W-1:0] up_id,
  input  logic            up_tmo,
  input  logic [ID_W-1:0] push_id,
  input  logic            push_tmo,
  input  logic [ID_W-1:0] key_id,
  input  logic            seen_in,
  output logic [ID_W-1:0] id_q,
  output logic            tmo_q,
  output logic            hit_q,
  output logic            seen_out
);
  import tcag_pkg::*;

  logic [ID_W-1:0] id_r;
  logic            tmo_r;
  logic            hit_r;
  logic            take;

  // shift in from the neighbor on a pop, or at and above the removed slot
  assign take     = ctl.pop || (ctl.remove && (seen_in || hit_r));
  assign seen_out = seen_in || hit_r;

  always_ff @(posedge clk) begin
    if (take) begin
      id_r  <= up_id;
      tmo_r <= up_tmo;
    end else if (ctl.push && is_tail) begin
      id_r  <= push_id;
      tmo_r <= push_tmo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctl.capture) begin
      hit_r <= occ && tmo_r && (id_r == key_id);
    end
  end

  assign id_q  = id_r;
  assign tmo_q = tmo_r;
  assign hit_q = hit_r;

endmodule

### src/tcag_queue.sv
// ----------------------------------------------------------------------------
// tcag_queue
// Wait queue of one category: a row of cells shifting toward the head,
// with fill count, push at tail, pop at head and removal of the first match.
// ----------------------------------------------------------------------------
module tcag_queue #(
  parameter int DEPTH = tcag_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_W  = tcag_pkg::ID_BITS_DEF,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcag_pkg::q_ctl_t ctl,
  input  logic [ID_W-1:0]  push_id,
  input  logic             push_tmo,
  input  logic [ID_W-1:0]  key_id,
  output logic [ID_W-1:0]  head_id,
  output logic [CW-1:0]    count,
  output logic             empty,
  output logic             full,
  output logic             any_hit
);
  import tcag_pkg::*;

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [ID_W-1:0] id_w   [DEPTH+1];
  logic            tmo_w  [DEPTH+1];
  logic            seen_w [DEPTH+1];
  logic [DEPTH-1:0] hit_w;

  assign id_w[DEPTH]  = '0;
  assign tmo_w[DEPTH] = 1'b0;
  assign seen_w[0]    = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(g);
    tcag_cell #(.ID_W(ID_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .occ      (IDX < count_r),
      .is_tail  (IDX == count_r),
      .up_id    (id_w[g+1]),
      .up_tmo   (tmo_w[g+1]),
      .push_id  (push_id),
      .push_tmo (push_tmo),
      .key_id   (key_id),
      .seen_in  (seen_w[g]),
      .id_q     (id_w[g]),
      .tmo_q    (tmo_w[g]),
      .hit_q    (hit_w[g]),
      .seen_out (seen_w[g+1])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push && !full) begin
      count_nxt = count_r + CW'(1);
    end else if ((ctl.pop && !empty) || (ctl.remove && any_hit)) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head_id = id_w[0];
  assign count   = count_r;
  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign any_hit = |hit_w;

endmodule

### src/two_class_alternating_grant.sv
// ----------------------------------------------------------------------------
// two_class_alternating_grant: shared resource arbiter for two categories
// Capture and match compare on acceptance, then the queue update.
// A new word is taken only after the last one leaves the execute state; the queue update waits for a free output.
// Reset (sync, rst_n low) empties both queues and frees the resource.
// ----------------------------------------------------------------------------
module two_class_alternating_grant #(
  parameter int QUEUE_DEPTH = tcag_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = tcag_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [tcag_pkg::FIELD_ID_W-1:0] in_client_id,
  input  logic                            in_category,
  input  logic                            in_has_timeout,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_outcome,
  output logic [tcag_pkg::FIELD_ID_W-1:0] out_grant_id,
  output logic                            out_grant_category
);
  import tcag_pkg::*;
  `include "two_class_alternating_grant_defines.svh"

  localparam int IDW = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  func_t           func_r;
  logic [IDW-1:0]  id_r;
  logic            cat_r;
  logic            tmo_r;
  logic            busy_r, busy_nxt;
  logic            owner_r, owner_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_outcome_r;
  logic [FIELD_ID_W-1:0] out_id_r;
  logic            out_cat_r;

  logic            accept;
  logic            go;
  q_ctl_t          ctl0, ctl1;
  logic [IDW-1:0]  key_id;
  logic [IDW-1:0]  head0, head1;
  logic [CW-1:0]   cnt0, cnt1;
  logic            empty0, empty1, full0, full1, hit0, hit1;
  outcome_t        res_oc;
  logic [IDW-1:0]  res_id;
  logic            res_cat;
  logic            opp;
  logic            pick;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign go       = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign key_id   = in_client_id[IDW-1:0];

  tcag_queue #(.DEPTH(QUEUE_DEPTH), .ID_W(IDW)) u_q0 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl0), .push_id(id_r), .push_tmo(tmo_r),
    .key_id(key_id), .head_id(head0), .count(cnt0), .empty(empty0),
    .full(full0), .any_hit(hit0)
  );

  tcag_queue #(.DEPTH(QUEUE_DEPTH), .ID_W(IDW)) u_q1 (
    .clk(clk), .rst_n(rst_n), .ctl(ctl1), .push_id(id_r), .push_tmo(tmo_r),
    .key_id(key_id), .head_id(head1), .count(cnt1), .empty(empty1),
    .full(full1), .any_hit(hit1)
  );

  always_comb begin
    ctl0         = '0;
    ctl1         = '0;
    ctl0.capture = accept;
    ctl1.capture = accept;
    busy_nxt     = busy_r;
    owner_nxt    = owner_r;
    res_oc       = OC_NONE;
    res_id       = '0;
    res_cat      = 1'b0;
    opp          = !owner_r;
    pick         = 1'b0;
    if (go) begin
      case (func_r)
        FN_REQUEST: begin
          res_id  = id_r;
          res_cat = cat_r;
          if (!busy_r) begin
            busy_nxt  = 1'b1;
            owner_nxt = cat_r;
            res_oc    = OC_GRANTED;
          end else if (cat_r ? full1 : full0) begin
            res_oc = OC_FULL;
          end else begin
            res_oc    = OC_QUEUED;
            ctl0.push = !cat_r;
            ctl1.push = cat_r;
          end
        end
        FN_RELEASE: begin
          if (busy_r) begin
            if (!(opp ? empty1 : empty0)) begin
              pick = opp;
            end else begin
              pick = owner_r;
            end
            if (empty0 && empty1) begin
              busy_nxt  = 1'b0;
              owner_nxt = 1'b0;
            end else begin
              owner_nxt = pick;
              res_oc    = OC_GRANTED;
              res_id    = pick ? head1 : head0;
              res_cat   = pick;
              ctl0.pop  = !pick;
              ctl1.pop  = pick;
            end
          end
        end
        FN_TIMEOUT: begin
          if (hit0) begin
            ctl0.remove = 1'b1;
            res_oc      = OC_REMOVED;
            res_id      = id_r;
          end else if (hit1) begin
            ctl1.remove = 1'b1;
            res_oc      = OC_REMOVED;
            res_id      = id_r;
            res_cat     = 1'b1;
          end
        end
        default: begin
          res_oc = OC_NONE;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= 1'b0;
      owner_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      owner_r     <= owner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func_t'(in_func);
      id_r   <= in_client_id[IDW-1:0];
      cat_r  <= in_category;
      tmo_r  <= in_has_timeout;
    end
    if (go) begin
      out_outcome_r <= res_oc;
      out_id_r      <= FIELD_ID_W'(res_id);
      out_cat_r     <= res_cat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_grant_id       = out_id_r;
  assign out_grant_category = out_cat_r;

  `TCAG_ASSERT(a_free_means_empty, !busy_r |-> (empty0 && empty1))
  `TCAG_ASSERT(a_count_bound, (cnt0 <= CW'(QUEUE_DEPTH)) && (cnt1 <= CW'(QUEUE_DEPTH)))
  `TCAG_ASSERT(a_remove_one, (go && (func_r == FN_TIMEOUT) && hit0) |=> (cnt0 == $past(cnt0) - CW'(1)))
  `TCAG_ASSERT_ALWAYS(a_result_after_exec, $rose(out_valid_r) |-> $past(state_r == ST_EXEC))

endmodule

### tb/tcag_grant_checker.sv
// ----------------------------------------------------------------------------
// tcag_grant_checker
// Watches both channels of the two-class alternating grant arbiter, keeps its
// own copy of the two wait lines and the owner, predicts the outcome word of
// every accepted request word and compares it field by field in order.
// ----------------------------------------------------------------------------
module tcag_grant_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [tcag_pkg::FIELD_ID_W-1:0] in_client_id,
  input  logic                            in_category,
  input  logic                            in_has_timeout,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [2:0]                      out_outcome,
  input  logic [tcag_pkg::FIELD_ID_W-1:0] out_grant_id,
  input  logic                            out_grant_category,
  output int                              mismatches,
  output int                              outstanding
);
  import tcag_pkg::*;

  localparam int LINE_DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic [FIELD_ID_W-1:0] id;
    logic                  tmo;
  } waiter_t;

  typedef struct packed {
    outcome_t              outcome;
    logic [FIELD_ID_W-1:0] id;
    logic                  cat;
  } grant_word_t;

  waiter_t     line_zero[$];
  waiter_t     line_one[$];
  logic        held;
  logic        owner;
  grant_word_t expected_outcomes[$];

  task automatic report(string msg);
    $display("tcag checker: %s", msg);
    mismatches++;
  endtask

  function automatic int line_len(logic cat);
    return cat ? line_one.size() : line_zero.size();
  endfunction

  // first waiter with a timeout and this id leaves its line
  function automatic logic drop_timed(logic cat, logic [FIELD_ID_W-1:0] id);
    if (cat) begin
      foreach (line_one[i]) begin
        if (line_one[i].tmo && line_one[i].id == id) begin
          line_one.delete(i);
          return 1'b1;
        end
      end
    end else begin
      foreach (line_zero[i]) begin
        if (line_zero[i].tmo && line_zero[i].id == id) begin
          line_zero.delete(i);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic grant_word_t arbitrate(logic [1:0] fn, logic [FIELD_ID_W-1:0] id,
                                            logic cat, logic tmo);
    grant_word_t w;
    waiter_t     head;
    waiter_t     joiner;
    logic        pick;
    w.outcome = OC_NONE;
    w.id      = '0;
    w.cat     = 1'b0;
    case (func_t'(fn))
      FN_REQUEST: begin
        w.id  = id;
        w.cat = cat;
        if (!held) begin
          held      = 1'b1;
          owner     = cat;
          w.outcome = OC_GRANTED;
        end else if (line_len(cat) >= LINE_DEPTH) begin
          w.outcome = OC_FULL;
        end else begin
          joiner.id  = id;
          joiner.tmo = tmo;
          if (cat) line_one.push_back(joiner);
          else line_zero.push_back(joiner);
          w.outcome = OC_QUEUED;
        end
      end
      FN_RELEASE: begin
        if (held) begin
          pick = ~owner;
          if (line_len(pick) == 0) pick = owner;
          if (line_len(pick) == 0) begin
            held  = 1'b0;
            owner = 1'b0;
          end else begin
            if (pick) head = line_one.pop_front();
            else head = line_zero.pop_front();
            owner     = pick;
            w.outcome = OC_GRANTED;
            w.id      = head.id;
            w.cat     = pick;
          end
        end
      end
      FN_TIMEOUT: begin
        if (drop_timed(1'b0, id)) begin
          w.outcome = OC_REMOVED;
          w.id      = id;
        end else if (drop_timed(1'b1, id)) begin
          w.outcome = OC_REMOVED;
          w.id      = id;
          w.cat     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    grant_word_t want;
    if (!rst_n) begin
      expected_outcomes.delete();
      line_zero.delete();
      line_one.delete();
      held  = 1'b0;
      owner = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outcomes.size() == 0) begin
          report($sformatf("word with nothing expected: outcome %0d id %0d cat %0d",
                           out_outcome, out_grant_id, out_grant_category));
        end else begin
          want = expected_outcomes.pop_front();
          if (out_outcome !== want.outcome)
            report($sformatf("outcome %0d, expected %0d", out_outcome, want.outcome));
          if (out_grant_id !== want.id)
            report($sformatf("grant_id %0d, expected %0d", out_grant_id, want.id));
          if (out_grant_category !== want.cat)
            report($sformatf("grant_category %0d, expected %0d", out_grant_category,
                             want.cat));
        end
      end
      if (in_valid && in_ready)
        expected_outcomes.push_back(arbitrate(in_func, in_client_id, in_category,
                                              in_has_timeout));
    end
    outstanding <= expected_outcomes.size();
  end

endmodule

### tb/tb_two_class_alternating_grant.sv
// ----------------------------------------------------------------------------
// tb_two_class_alternating_grant
// Drives request, release and timeout words into the arbiter: a directed
// opening, a queue fill to overflow, then random bursts with random idling on
// both sides and one long output stall. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_two_class_alternating_grant;
  import tcag_pkg::*;

  localparam int ITEM_TARGET  = 1100;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 240;
  localparam int HOLD_AT      = 820;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_func = FN_REQUEST;
  logic [FIELD_ID_W-1:0] in_client_id = '0;
  logic                  in_category = 1'b0;
  logic                  in_has_timeout = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            out_outcome;
  logic [FIELD_ID_W-1:0] out_grant_id;
  logic                  out_grant_category;

  int                    mismatches;
  int                    outstanding;
  int                    words_sent = 0;
  int                    sender_idle_pct = 25;
  int                    receiver_idle_pct = 57;
  int                    quiet_cycles = 0;
  logic [FIELD_ID_W-1:0] recent_ids[$];

  two_class_alternating_grant dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_client_id       (in_client_id),
    .in_category        (in_category),
    .in_has_timeout     (in_has_timeout),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_grant_id       (out_grant_id),
    .out_grant_category (out_grant_category)
  );

  tcag_grant_checker grant_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_client_id       (in_client_id),
    .in_category        (in_category),
    .in_has_timeout     (in_has_timeout),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_outcome        (out_outcome),
    .out_grant_id       (out_grant_id),
    .out_grant_category (out_grant_category),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_two_class_alternating_grant: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off while input keeps coming
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  task automatic send_word(func_t fn, logic [FIELD_ID_W-1:0] id, logic cat, logic tmo);
    if (words_sent < 380) begin
      sender_idle_pct   = 25;
      receiver_idle_pct = 57;
    end else if (words_sent < 760) begin
      sender_idle_pct   = 57;
      receiver_idle_pct = 25;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= fn;
    in_client_id   <= id;
    in_category    <= cat;
    in_has_timeout <= tmo;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (fn == FN_REQUEST) begin
      recent_ids.push_back(id);
      if (recent_ids.size() > 24) void'(recent_ids.pop_front());
    end
  endtask

  // half full-range ids, half a small pool so ids repeat
  function automatic logic [FIELD_ID_W-1:0] pick_id();
    if ($urandom_range(1)) return FIELD_ID_W'($urandom_range(255));
    return FIELD_ID_W'($urandom_range(7));
  endfunction

  task automatic random_episode();
    int               kind;
    int               len;
    int               bias;
    logic [FIELD_ID_W-1:0] id;
    logic             cat;
    kind = $urandom_range(99);
    len  = $urandom_range(20, 1);
    if (kind < 40) begin
      bias = $urandom_range(2);
      repeat (len) begin
        if (bias == 2) cat = 1'($urandom_range(1));
        else cat = ($urandom_range(9) < 8) ? bias[0] : ~bias[0];
        send_word(FN_REQUEST, pick_id(), cat, 1'($urandom_range(1)));
      end
    end else if (kind < 70) begin
      repeat (len)
        send_word(FN_RELEASE, pick_id(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (kind < 90) begin
      repeat ($urandom_range(6, 1)) begin
        if (recent_ids.size() != 0 && $urandom_range(4) != 0)
          id = recent_ids[$urandom_range(recent_ids.size() - 1)];
        else
          id = pick_id();
        send_word(FN_TIMEOUT, id, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end else begin
      repeat ($urandom_range(4, 1))
        send_word(func_t'($urandom_range(3)), FIELD_ID_W'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);
    send_word(FN_TIMEOUT, 8'h12, 1'b0, 1'b1);
    send_word(FN_UNUSED,  8'hFF, 1'b1, 1'b1);
    send_word(FN_REQUEST, 8'h00, 1'b0, 1'b0);
    send_word(FN_REQUEST, 8'hFF, 1'b1, 1'b1);
    send_word(FN_REQUEST, 8'hAA, 1'b0, 1'b1);
    send_word(FN_REQUEST, 8'h55, 1'b1, 1'b0);
    send_word(FN_REQUEST, 8'h3C, 1'b0, 1'b0);
    send_word(FN_REQUEST, 8'h3C, 1'b1, 1'b1);
    send_word(FN_REQUEST, 8'h3C, 1'b0, 1'b1);
    send_word(FN_TIMEOUT, 8'h3C, 1'b1, 1'b0);
    send_word(FN_TIMEOUT, 8'h3C, 1'b0, 1'b1);
    send_word(FN_TIMEOUT, 8'h3C, 1'b0, 1'b0);
    send_word(FN_TIMEOUT, 8'h55, 1'b1, 1'b1);
    send_word(FN_RELEASE, 8'hFF, 1'b1, 1'b1);
    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);
    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);
    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);
    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);
    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);
    send_word(FN_REQUEST, 8'h81, 1'b1, 1'b1);
    send_word(FN_REQUEST, 8'h7E, 1'b1, 1'b0);
    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);
    send_word(FN_TIMEOUT, 8'hFF, 1'b1, 1'b1);
    send_word(FN_RELEASE, 8'h00, 1'b0, 1'b0);

    // one grant, sixteen queued, then overflow
    repeat (18) send_word(FN_REQUEST, pick_id(), 1'b1, 1'($urandom_range(1)));

    while (words_sent < ITEM_TARGET) random_episode();

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_two_class_alternating_grant: PASS");
    end else begin
      $display("tb_two_class_alternating_grant: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/tcag_pkg.sv
src/tcag_cell.sv
src/tcag_queue.sv
src/two_class_alternating_grant.sv
tb/tcag_grant_checker.sv
tb/tb_two_class_alternating_grant.sv
